// File: hw/rtl/kps_pkg.sv
// Package for the matrix keypad scanner: configuration and result structures,
// register indexes, reset values and the key remapping function.
// Depends on nothing; kps_cfg, kps_fsm and the top level refer to it.
`default_nettype none

package kps_pkg;

	localparam int DEF_MAX_ROWS = 4;
	localparam int DEF_MAX_COLS = 4;
	localparam int TICK_W       = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd5;

	localparam logic [1:0] LAYOUT_RAW   = 2'd0;
	localparam logic [1:0] LAYOUT_PHONE = 2'd1;
	localparam logic [1:0] LAYOUT_CALC  = 2'd2;

	localparam logic [2:0]        RST_ROWS     = 3'd4;
	localparam logic [2:0]        RST_COLS     = 3'd4;
	localparam logic [1:0]        RST_LAYOUT   = LAYOUT_CALC;
	localparam logic              RST_LEVEL    = 1'b0;
	localparam logic [TICK_W-1:0] RST_DEBOUNCE = 16'd20;
	localparam logic [TICK_W-1:0] RST_GAP      = 16'd5;

	localparam logic [7:0] CH_STAR    = 8'd42;
	localparam logic [7:0] CH_HASH    = 8'd35;
	localparam logic [7:0] CH_PERCENT = 8'd37;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_EQUALS  = 8'd61;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_ENTER   = 8'd13;

	typedef struct packed {
		logic [2:0]        rows_in_use;
		logic [2:0]        cols_in_use;
		logic [1:0]        layout;
		logic              pressed_level;
		logic [TICK_W-1:0] debounce_ticks;
		logic [TICK_W-1:0] row_gap_ticks;
	} kps_cfg_t;

	typedef struct packed {
		logic [7:0] key_code;
		logic       key_valid;
		logic [1:0] row_index;
		logic       row_drive_on;
	} kps_result_t;

	localparam logic [7:0] CALC_MAP [16] = '{
		8'd7, 8'd8, 8'd9, CH_PERCENT,
		8'd4, 8'd5, 8'd6, CH_STAR,
		8'd1, 8'd2, 8'd3, CH_MINUS,
		CH_ENTER, 8'd0, CH_EQUALS, CH_PLUS
	};

	function automatic logic [7:0] map_key(input logic [1:0] layout, input logic [7:0] n);
		logic [7:0] code;
		logic [7:0] nm1;
		code = n;
		nm1  = n - 8'd1;
		case (layout)
			LAYOUT_PHONE: begin
				if (n == 8'd10) code = CH_STAR;
				else if (n == 8'd11) code = 8'd0;
				else if (n == 8'd12) code = CH_HASH;
			end
			LAYOUT_CALC: begin
				if (n >= 8'd1 && n <= 8'd16) code = CALC_MAP[nm1[3:0]];
			end
			default: code = n;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kps_cfg.sv
// Configuration register file of the keypad scanner.
// Written through a plain write port; uses kps_pkg for indexes and reset values.
`default_nettype none

module kps_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [kps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output kps_pkg::kps_cfg_t                    cfg
);

	kps_pkg::kps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use    <= kps_pkg::RST_ROWS;
			cfg_q.cols_in_use    <= kps_pkg::RST_COLS;
			cfg_q.layout         <= kps_pkg::RST_LAYOUT;
			cfg_q.pressed_level  <= kps_pkg::RST_LEVEL;
			cfg_q.debounce_ticks <= kps_pkg::RST_DEBOUNCE;
			cfg_q.row_gap_ticks  <= kps_pkg::RST_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				kps_pkg::REG_ROWS:     cfg_q.rows_in_use    <= cfg_data[2:0];
				kps_pkg::REG_COLS:     cfg_q.cols_in_use    <= cfg_data[2:0];
				kps_pkg::REG_LAYOUT:   cfg_q.layout         <= cfg_data[1:0];
				kps_pkg::REG_LEVEL:    cfg_q.pressed_level  <= cfg_data[0];
				kps_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				kps_pkg::REG_GAP:      cfg_q.row_gap_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/kps_fsm.sv
// Scan state machine of the keypad scanner: one step per accepted tick,
// registering the state and the result of that tick. Uses kps_pkg.
`default_nettype none

module kps_fsm #(
	parameter int MAX_ROWS = kps_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = kps_pkg::DEF_MAX_COLS,
	parameter int ROW_W    = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [3:0]    levels,
	input  kps_pkg::kps_cfg_t  cfg,
	output kps_pkg::kps_result_t result
);

	localparam int COL_CAP = (MAX_COLS < 4) ? MAX_COLS : 4;

	typedef enum logic [1:0] {
		PH_SCAN,
		PH_DEBOUNCE,
		PH_WAIT,
		PH_GAP
	} phase_t;

	phase_t                        phase_q;
	logic [ROW_W-1:0]              row_q;
	logic [1:0]                    hit_q;
	logic [kps_pkg::TICK_W-1:0]    tick_q;
	kps_pkg::kps_result_t          result_q;

	logic [3:0]                    eff_rows;
	logic [2:0]                    eff_cols;
	logic [ROW_W-1:0]              row_cur;
	logic [ROW_W:0]                row_inc;
	logic [ROW_W-1:0]              row_next;
	logic                          hit;
	logic [1:0]                    hit_col;
	logic                          released;
	logic [kps_pkg::TICK_W-1:0]    tick_dec;
	logic [7:0]                    key_num;
	logic                          drive_on;
	logic                          key_fire;
	logic [7:0]                    key_code_d;

	always_comb begin
		eff_rows = {1'b0, cfg.rows_in_use};
		if (eff_rows == 4'd0) eff_rows = 4'd1;
		if (eff_rows > 4'(MAX_ROWS)) eff_rows = 4'(MAX_ROWS);

		eff_cols = cfg.cols_in_use;
		if (eff_cols == 3'd0) eff_cols = 3'd1;
		if (eff_cols > 3'(COL_CAP)) eff_cols = 3'(COL_CAP);

		row_cur = row_q;
		if (phase_q == PH_SCAN && 4'(row_q) >= eff_rows) row_cur = '0;

		row_inc  = (ROW_W+1)'(row_cur) + (ROW_W+1)'(1);
		row_next = (4'(row_inc) >= eff_rows) ? '0 : row_inc[ROW_W-1:0];

		hit     = 1'b0;
		hit_col = 2'd0;
		for (int c = 0; c < 4; c++) begin
			if (!hit && 3'(c) < eff_cols && levels[c] == cfg.pressed_level) begin
				hit     = 1'b1;
				hit_col = 2'(c);
			end
		end

		released = (levels[hit_q] != cfg.pressed_level);
		tick_dec = tick_q - kps_pkg::TICK_W'(1);
		key_num  = 8'(row_q) * 8'(eff_cols) + 8'(hit_q) + 8'd1;

		drive_on   = (phase_q != PH_GAP);
		key_fire   = (phase_q == PH_WAIT) && released;
		key_code_d = key_fire ? kps_pkg::map_key(cfg.layout, key_num) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SCAN;
			row_q    <= '0;
			hit_q    <= 2'd0;
			tick_q   <= '0;
			result_q <= '0;
		end else if (step) begin
			result_q.row_drive_on <= drive_on;
			result_q.row_index    <= 2'(row_cur);
			result_q.key_valid    <= key_fire;
			result_q.key_code     <= key_code_d;
			case (phase_q)
				PH_SCAN: begin
					if (hit) begin
						row_q   <= row_cur;
						hit_q   <= hit_col;
						tick_q  <= cfg.debounce_ticks;
						phase_q <= (cfg.debounce_ticks == '0) ? PH_WAIT : PH_DEBOUNCE;
					end else if (cfg.row_gap_ticks == '0) begin
						row_q   <= row_next;
						phase_q <= PH_SCAN;
					end else begin
						row_q   <= row_cur;
						tick_q  <= cfg.row_gap_ticks;
						phase_q <= PH_GAP;
					end
				end
				PH_DEBOUNCE: begin
					tick_q <= tick_dec;
					if (tick_dec == '0) phase_q <= PH_WAIT;
				end
				PH_WAIT: begin
					if (released) begin
						row_q   <= '0;
						phase_q <= PH_SCAN;
					end
				end
				PH_GAP: begin
					tick_q <= tick_dec;
					if (tick_dec == '0) begin
						row_q   <= row_next;
						phase_q <= PH_SCAN;
					end
				end
				default: phase_q <= PH_SCAN;
			endcase
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// File: hw/rtl/matrix_keypad_scanner.sv
// Top level of the matrix keypad scanner: input register, scan state machine,
// configuration registers and output register. Uses kps_pkg, kps_cfg, kps_fsm.
//
// The input stream carries one transaction per scan tick (about 1 ms), holding
// the sampled column levels. Every input transaction yields exactly one output
// transaction: whether a row is driven, which row, and on the release of a
// captured key a valid flag with the mapped key code (zero otherwise).
// The row and column counts, key layout, pressed level, debounce length and
// row gap are set through the write port; the user must write them only while
// the block is idle; the block itself does not enforce this. A tick is taken
// into the input register, and when the state machine steps, the result lands
// in the output register. Throughput is one tick per cycle while the receiver
// does not stall, set by the single state machine step between the registers.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more tick; input ready then falls until the
// output is taken. Reset clears all state: scanning starts at row 0 and the
// configuration returns to four rows, four columns, calculator layout, active
// low, debounce 20 and gap 5.
`default_nettype none

module matrix_keypad_scanner #(
	parameter int MAX_ROWS = kps_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = kps_pkg::DEF_MAX_COLS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [7:0]                      s_tdata,   // [3:0] column_levels
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [0] row_drive_on, [2:1] row_index, [3] key_valid, [11:4] key_code
	output      logic [15:0]                     m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [kps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic                  valid_s1;
	logic [3:0]            levels_s1;
	logic                  m_valid_q;
	logic                  advance;
	logic                  step;
	kps_pkg::kps_cfg_t     cfg;
	kps_pkg::kps_result_t  result;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			levels_s1 <= 4'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1  <= s_tvalid;
				levels_s1 <= s_tdata[3:0];
			end
			if (advance) m_valid_q <= valid_s1;
		end
	end

	kps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kps_fsm #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.ROW_W    (ROW_W)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.levels (levels_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, result.key_code, result.key_valid,
		result.row_index, result.row_drive_on};

endmodule

`default_nettype wire

// File: hw/rtl/kps_checker.sv
// Port-level checker for the matrix keypad scanner, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module kps_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled result changed or was dropped.");

	a_key_driven: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0])
		else $error("Key reported while the row was released.");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0)
		else $error("Key code non-zero without a key.");

	a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("Result appeared without a pending transaction.");

endmodule

bind matrix_keypad_scanner kps_port_checks u_kps_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
